// ----- hw/rtl/rcia_pkg.sv -----
// Shared types, codes and constants of the reference-counted identifier allocator.
`default_nettype none

package rcia_pkg;

    localparam int unsigned ID_W        = 8;
    localparam int unsigned NUM_IDS     = 1 << ID_W;
    localparam int unsigned OP_W        = 3;
    localparam int unsigned STATUS_W    = 3;
    localparam int unsigned COUNT_OUT_W = 16;
    localparam int unsigned GRP_W       = 4;
    localparam int unsigned GRP_SIZE    = 1 << GRP_W;
    localparam int unsigned GSEL_W      = ID_W - GRP_W;
    localparam int unsigned NUM_GRPS    = 1 << GSEL_W;

    localparam logic [ID_W-1:0] NO_IDENT = '1;

    localparam int unsigned DEF_ID_LIMIT   = 255;
    localparam int unsigned DEF_COUNT_BITS = 16;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC  = 3'd0,
        OP_ADD    = 3'd1,
        OP_DROP   = 3'd2,
        OP_QUERY  = 3'd3,
        OP_CLEAR  = 3'd4,
        OP_INIT   = 3'd5,
        OP_UNINIT = 3'd6
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 3'd0,
        STAT_NOT_INIT  = 3'd1,
        STAT_ALREADY   = 3'd2,
        STAT_NOT_FOUND = 3'd3,
        STAT_EXHAUSTED = 3'd4,
        STAT_SATURATED = 3'd5
    } t_status;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } t_state;

    // Lowest identifier on the freed set, as seen by the allocation step.
    typedef struct packed {
        logic            found;
        logic [ID_W-1:0] idx;
    } t_free_pick;

endpackage

`default_nettype wire

// ----- hw/rtl/rcia_if.sv -----
// Request and response channel interfaces of the identifier allocator.
`default_nettype none

interface rcia_req_if;
    logic                       valid;
    logic                       ready;
    logic [rcia_pkg::OP_W-1:0]  op;
    logic [rcia_pkg::ID_W-1:0]  ident;

    modport source (output valid, output op, output ident, input ready);
    modport sink   (input valid, input op, input ident, output ready);
endinterface

interface rcia_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [rcia_pkg::STATUS_W-1:0]     status;
    logic [rcia_pkg::ID_W-1:0]         ident_out;
    logic [rcia_pkg::COUNT_OUT_W-1:0]  ref_count;
    logic                              present;
    logic [rcia_pkg::ID_W-1:0]         live_count;

    modport source (output valid, output status, output ident_out, output ref_count,
                    output present, output live_count, input ready);
    modport sink   (input valid, input status, input ident_out, input ref_count,
                    input present, input live_count, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/refcounted_id_allocator.sv -----
// Top level of the reference-counted identifier allocator.
//
// Requests arrive on i_req (op, ident) and each produces exactly one
// response on o_rsp (status, ident_out, ref_count, present, live_count).
// Both channels use a valid/ready handshake; a transfer happens on a rising
// edge of i_clk where both are high.
// Each request has an accept cycle, which also issues the read of the
// count memory at ident, and an execute cycle, which uses the registered
// read data, updates the allocation bitmaps and writes the count back.
// The response is registered: the state register and then the response
// register lie between the accept and the response. One request is in
// flight at a time, so a new request is accepted only after the current
// one has finished its execute cycle; the registered count memory read and
// the registered first level of the freed-set encoder call for that cycle.
// The response register decouples the channels: a new request is accepted
// while an earlier response still waits. If the receiver stalls long enough
// that a second response is ready, the execute cycle holds until the
// response register frees up, and no further request is accepted meanwhile.
// Synchronous reset leaves the allocator uninitialized with empty bitmaps;
// the count memory is not cleared because a count is only used for an
// identifier whose in-use bit is set, and allocation writes it first.
`default_nettype none

module refcounted_id_allocator #(
    parameter int unsigned ID_LIMIT   = rcia_pkg::DEF_ID_LIMIT,
    parameter int unsigned COUNT_BITS = rcia_pkg::DEF_COUNT_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rcia_req_if.sink    i_req,
    rcia_rsp_if.source  o_rsp
);
    import rcia_pkg::*;

    // Counts never exceed the 16-bit output range, so storage stops there.
    localparam int unsigned CW        = (COUNT_BITS < COUNT_OUT_W) ? COUNT_BITS : COUNT_OUT_W;
    localparam int unsigned EFF_LIMIT = (ID_LIMIT < 255) ? ID_LIMIT : 255;

    // Control state.
    t_state              r_state;
    t_state              n_state;
    logic                r_init;
    logic                n_init;
    logic [NUM_IDS-1:0]  r_in_use;
    logic [NUM_IDS-1:0]  n_in_use;
    logic [NUM_IDS-1:0]  r_freed;
    logic [NUM_IDS-1:0]  n_freed;
    logic [ID_W-1:0]     r_next_fresh;
    logic [ID_W-1:0]     n_next_fresh;
    logic [ID_W-1:0]     r_live;
    logic [ID_W-1:0]     n_live;

    // Captured request.
    logic [OP_W-1:0]     r_op;
    logic [ID_W-1:0]     r_ident;

    // Count memory and its registered read port.
    logic [CW-1:0]       mem_cnt [NUM_IDS];
    logic [CW-1:0]       r_cnt_rd;
    logic [ID_W-1:0]     mem_ra;
    logic                mem_we;
    logic [ID_W-1:0]     mem_wa;
    logic [CW-1:0]       mem_wd;

    // Response register.
    logic                r_out_valid;
    t_status             r_out_status;
    logic [ID_W-1:0]     r_out_ident;
    logic [COUNT_OUT_W-1:0] r_out_count;
    logic                r_out_present;
    logic [ID_W-1:0]     r_out_live;

    // Execute-cycle results.
    t_status             res_status;
    logic [ID_W-1:0]     res_ident;
    logic [CW-1:0]       res_count;
    logic                res_present;

    logic                in_ready;
    logic                in_fire;
    logic                exec_fire;
    t_free_pick          free_pick;

    rcia_lowfree u_lowfree (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_freed (r_freed),
        .o_pick  (free_pick)
    );

    // ---------------------------------------------------------------
    // Sequencer: accept in IDLE, finish in EXEC once the response
    // register can take the result.
    // ---------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (exec_fire) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        in_ready  = 1'b0;
        exec_fire = 1'b0;
        unique case (r_state)
            ST_IDLE: in_ready  = 1'b1;
            ST_EXEC: exec_fire = !r_out_valid || o_rsp.ready;
            default: ;
        endcase
    end

    assign i_req.ready = in_ready;
    assign in_fire     = i_req.valid && in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_op    <= i_req.op;
            r_ident <= i_req.ident;
        end
    end

    // The read is launched in the accept cycle so the count is ready for
    // the execute cycle; while execute stalls the same entry is reread.
    assign mem_ra = (r_state == ST_IDLE) ? i_req.ident : r_ident;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_cnt[mem_wa] <= mem_wd;
        end
        r_cnt_rd <= mem_cnt[mem_ra];
    end

    // ---------------------------------------------------------------
    // Execute step: read-modify-write of the count and the bitmaps.
    // ---------------------------------------------------------------
    always_comb begin
        n_init       = r_init;
        n_in_use     = r_in_use;
        n_freed      = r_freed;
        n_next_fresh = r_next_fresh;
        n_live       = r_live;
        mem_we       = 1'b0;
        mem_wa       = r_ident;
        mem_wd       = r_cnt_rd;
        res_status   = STAT_OK;
        res_ident    = NO_IDENT;
        res_count    = '0;
        res_present  = 1'b0;

        case (r_op) inside
            OP_ADD, OP_DROP, OP_QUERY: res_ident = r_ident;
            default: ;
        endcase

        case (r_op) inside
            OP_INIT: begin
                if (r_init) begin
                    res_status = STAT_ALREADY;
                end else begin
                    n_init       = 1'b1;
                    n_in_use     = '0;
                    n_freed      = '0;
                    n_next_fresh = '0;
                    n_live       = '0;
                end
            end
            OP_ALLOC, OP_ADD, OP_DROP, OP_QUERY, OP_CLEAR, OP_UNINIT: begin
                if (!r_init) begin
                    res_status = STAT_NOT_INIT;
                end else begin
                    case (r_op) inside
                        OP_ALLOC: begin
                            if (free_pick.found || (r_next_fresh < ID_W'(EFF_LIMIT))) begin
                                if (free_pick.found) begin
                                    res_ident                = free_pick.idx;
                                    n_freed[free_pick.idx]   = 1'b0;
                                end else begin
                                    res_ident    = r_next_fresh;
                                    n_next_fresh = r_next_fresh + 1'b1;
                                end
                                n_in_use[res_ident] = 1'b1;
                                n_live              = r_live + 1'b1;
                                mem_we              = 1'b1;
                                mem_wa              = res_ident;
                                mem_wd              = CW'(1);
                                res_count           = CW'(1);
                                res_present         = 1'b1;
                            end else begin
                                res_status = STAT_EXHAUSTED;
                            end
                        end
                        OP_ADD, OP_DROP, OP_QUERY: begin
                            if (!r_in_use[r_ident]) begin
                                res_status = STAT_NOT_FOUND;
                            end else begin
                                res_present = 1'b1;
                                res_count   = r_cnt_rd;
                                if (r_op == OP_ADD) begin
                                    // All ones is the saturation point of the count.
                                    if (&r_cnt_rd) begin
                                        res_status = STAT_SATURATED;
                                    end else begin
                                        mem_we    = 1'b1;
                                        mem_wd    = r_cnt_rd + 1'b1;
                                        res_count = mem_wd;
                                    end
                                end else if (r_op == OP_DROP) begin
                                    mem_we    = 1'b1;
                                    mem_wd    = r_cnt_rd - 1'b1;
                                    res_count = mem_wd;
                                    if (mem_wd == '0) begin
                                        n_in_use[r_ident] = 1'b0;
                                        n_freed[r_ident]  = 1'b1;
                                        n_live            = r_live - 1'b1;
                                        res_present       = 1'b0;
                                    end
                                end
                            end
                        end
                        OP_CLEAR, OP_UNINIT: begin
                            n_in_use     = '0;
                            n_freed      = '0;
                            n_next_fresh = '0;
                            n_live       = '0;
                            if (r_op == OP_UNINIT) begin
                                n_init = 1'b0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase

        if (!exec_fire) begin
            mem_we = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init       <= 1'b0;
            r_in_use     <= '0;
            r_freed      <= '0;
            r_next_fresh <= '0;
            r_live       <= '0;
        end else if (exec_fire) begin
            r_init       <= n_init;
            r_in_use     <= n_in_use;
            r_freed      <= n_freed;
            r_next_fresh <= n_next_fresh;
            r_live       <= n_live;
        end
    end

    // ---------------------------------------------------------------
    // Response register.
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (exec_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec_fire) begin
            r_out_status  <= res_status;
            r_out_ident   <= res_ident;
            r_out_count   <= COUNT_OUT_W'(res_count);
            r_out_present <= res_present;
            r_out_live    <= n_live;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.status     = r_out_status;
    assign o_rsp.ident_out  = r_out_ident;
    assign o_rsp.ref_count  = r_out_count;
    assign o_rsp.present    = r_out_present;
    assign o_rsp.live_count = r_out_live;

`ifndef SYNTHESIS
    // An identifier is never both allocated and waiting for reuse.
    a_disjoint_sets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_use & r_freed) == '0)
        else $error("identifier both in use and freed");

    // The live total tracks the in-use bitmap.
    a_live_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live == ID_W'($countones(r_in_use)))
        else $error("live count out of step with in-use bitmap");

    // The no-identifier code is never handed out.
    a_no_ident_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_use[NO_IDENT] && !r_freed[NO_IDENT])
        else $error("reserved identifier entered the bitmaps");

    // While closed, the allocator holds nothing.
    a_closed_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_init |-> (r_in_use == '0 && r_live == '0))
        else $error("allocator holds identifiers while uninitialized");

    // The encoder's pick is on the freed set when allocation uses it.
    a_pick_is_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EXEC && free_pick.found) |-> r_freed[free_pick.idx])
        else $error("reuse pick is not a freed identifier");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/rcia_lowfree.sv -----
// Two-level priority encoder that finds the lowest identifier on the freed set.
`default_nettype none

module rcia_lowfree (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [rcia_pkg::NUM_IDS-1:0]   i_freed,
    output rcia_pkg::t_free_pick           o_pick
);
    import rcia_pkg::*;

    logic [NUM_GRPS-1:0] r_grp_any;
    logic [NUM_GRPS-1:0] n_grp_any;
    logic [GRP_W-1:0]    r_grp_low [NUM_GRPS];
    logic [GRP_W-1:0]    n_grp_low [NUM_GRPS];

    // First level: per group of sixteen, a nonempty flag and the lowest set bit.
    always_comb begin
        for (int g = 0; g < NUM_GRPS; g++) begin
            n_grp_any[g] = |i_freed[g*GRP_SIZE +: GRP_SIZE];
            n_grp_low[g] = '0;
            for (int b = GRP_SIZE - 1; b >= 0; b--) begin
                if (i_freed[g*GRP_SIZE + b]) begin
                    n_grp_low[g] = GRP_W'(b);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grp_any <= '0;
        end else begin
            r_grp_any <= n_grp_any;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int g = 0; g < NUM_GRPS; g++) begin
            r_grp_low[g] <= n_grp_low[g];
        end
    end

    // Second level: the lowest nonempty group supplies the upper index bits.
    always_comb begin
        o_pick.found = |r_grp_any;
        o_pick.idx   = '0;
        for (int g = NUM_GRPS - 1; g >= 0; g--) begin
            if (r_grp_any[g]) begin
                o_pick.idx = {GSEL_W'(g), r_grp_low[g]};
            end
        end
    end

endmodule

`default_nettype wire
